// ===== rtl/nntl_pkg.sv =====
// Shared types and constants of the nearest-neighbor tour core.
package nntl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 32;
    localparam int IDX_W          = 6;
    localparam int Q_DEPTH        = 2;
    localparam int Q_AW           = 1;
    localparam int DIST_W         = COORD_W + 1;

    // One input word: a waypoint, with the list end mark.
    typedef struct packed {
        logic [COORD_W-1:0] easting;
        logic [COORD_W-1:0] northing;
        logic               list_end;
    } t_in_word;

    // One result word: a visited point in tour order.
    typedef struct packed {
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] out_easting;
        logic [COORD_W-1:0] out_northing;
        logic               tour_end;
        logic               overflow;
    } t_out_word;

    // Classified word handed from the front to the tour engine.
    typedef struct packed {
        logic               store;
        logic               last;
        logic               overflow;
        logic [COORD_W-1:0] easting;
        logic [COORD_W-1:0] northing;
    } t_q_word;

    // Queue handshake seen by one side.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

// ===== rtl/nntl_front.sv =====
// Input front: accepts waypoint words, tracks fill of the list, classifies each word.
module nntl_front import nntl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_word i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_busy,
    output logic     o_push,
    output t_q_word  o_q_word
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_stored, n_stored;
    logic          r_dropped, n_dropped;
    logic          fits;

    assign o_busy = i_q_stat.full;
    assign o_push = i_start && !i_q_stat.full;
    assign fits   = (r_stored < CW'(MAX_POINTS));

    always_comb begin
        o_q_word.store    = fits;
        o_q_word.last     = i_item.list_end;
        o_q_word.overflow = r_dropped || !fits;
        o_q_word.easting  = i_item.easting;
        o_q_word.northing = i_item.northing;
    end

    always_comb begin
        n_stored  = r_stored;
        n_dropped = r_dropped;
        if (o_push) begin
            if (i_item.list_end) begin
                n_stored  = '0;
                n_dropped = 1'b0;
            end else if (fits) begin
                n_stored = r_stored + CW'(1);
            end else begin
                n_dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored  <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_stored  <= n_stored;
            r_dropped <= n_dropped;
        end
    end

endmodule

// ===== rtl/nntl_queue.sv =====
// Two-entry queue between the front and the tour engine.
module nntl_queue import nntl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_word i_word,
    input  logic    i_pop,
    output t_q_word o_word,
    output t_q_stat o_stat
);

    t_q_word           r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]     r_fill, n_fill;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.valid = (r_fill != '0);
    assign o_word       = r_slot[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;

    always_comb begin
        n_fill = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + (Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_fill <= n_fill;
        end
    end

endmodule

// ===== rtl/nntl_back.sv =====
// Tour engine: point store, greedy nearest-neighbor scan and result emission.
module nntl_back import nntl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    input  t_q_word   i_q_word,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_word o_result
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int MW  = 2 * COORD_W + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    // entry layout: {visited, easting, northing}
    logic [MW-1:0]      mem [MAX_POINTS];
    logic [MW-1:0]      r_rd_data;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [MW-1:0]      wr_data;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_wptr, n_wptr;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CW-1:0]      r_done, n_done;
    logic [AW-1:0]      r_best, n_best;
    logic [DIST_W-1:0]  r_best_d, n_best_d;
    logic               r_found, n_found;
    logic [CW-1:0]      r_scan, n_scan;
    logic [COORD_W-1:0] r_cur_e, r_cur_n;
    logic               r_v1, r_v2, n_v1;
    logic [AW-1:0]      r_i1, r_i2;
    logic               r_vis2;
    logic [COORD_W-1:0] r_de, r_dn;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic [COORD_W-1:0] m_e, m_n;
    logic               m_vis;
    logic [DIST_W-1:0]  cand_d;
    logic               issue;
    logic               tour_last;

    assign m_vis = r_rd_data[MW-1];
    assign m_e   = r_rd_data[MW-2 -: COORD_W];
    assign m_n   = r_rd_data[COORD_W-1:0];

    assign issue     = (r_state == S_SCAN) && (r_scan < r_count);
    assign tour_last = ((r_done + CW'(1)) == r_count);
    assign cand_d    = DIST_W'(r_de) + DIST_W'(r_dn);

    assign o_pop    = (r_state == S_IDLE) && i_q_stat.valid;
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // Memory ports
    always_comb begin
        rd_en   = (r_state == S_FETCH) || issue;
        rd_addr = (r_state == S_FETCH) ? r_best : r_scan[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_wptr[AW-1:0];
        wr_data = {1'b0, i_q_word.easting, i_q_word.northing};
        if (o_pop && i_q_word.store) begin
            wr_en = 1'b1;
        end else if (r_state == S_EMIT) begin
            wr_en   = 1'b1;
            wr_addr = r_best;
            wr_data = {1'b1, m_e, m_n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_done      = r_done;
        n_best      = r_best;
        n_best_d    = r_best_d;
        n_found     = r_found;
        n_scan      = r_scan;
        n_v1        = issue;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (i_q_word.store) begin
                        n_wptr = r_wptr + CW'(1);
                    end
                    if (i_q_word.last) begin
                        n_count = r_wptr + CW'(i_q_word.store);
                        n_ovf   = i_q_word.overflow;
                        n_wptr  = '0;
                        n_done  = '0;
                        n_best  = '0;
                        if (n_count != '0) begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out_valid          = 1'b1;
                n_out.point_index    = IDX_W'(r_best);
                n_out.out_easting    = m_e;
                n_out.out_northing   = m_n;
                n_out.tour_end       = tour_last;
                n_out.overflow       = r_ovf;
                n_done               = r_done + CW'(1);
                n_scan               = '0;
                n_found              = 1'b0;
                n_state              = tour_last ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (issue) begin
                    n_scan = r_scan + CW'(1);
                end
                // compare stage: keep first minimum, so ties go to the lower index
                if (r_v2 && !r_vis2 && (!r_found || cand_d < r_best_d)) begin
                    n_found  = 1'b1;
                    n_best_d = cand_d;
                    n_best   = r_i2;
                end
                if (!issue && !r_v1 && !r_v2) begin
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Distance stage and payload registers
    always_ff @(posedge i_clk) begin
        r_i1   <= rd_addr;
        r_i2   <= r_i1;
        r_vis2 <= m_vis;
        r_de   <= (m_e >= r_cur_e) ? (m_e - r_cur_e) : (r_cur_e - m_e);
        r_dn   <= (m_n >= r_cur_n) ? (m_n - r_cur_n) : (r_cur_n - m_n);
        if (r_state == S_EMIT) begin
            r_cur_e <= m_e;
            r_cur_n <= m_n;
        end
        r_count  <= n_count;
        r_ovf    <= n_ovf;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_done      <= '0;
            r_found     <= 1'b0;
            r_scan      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_done      <= n_done;
            r_found     <= n_found;
            r_scan      <= n_scan;
            r_v1        <= n_v1;
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
        end
    end

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe without an emit step");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tour_end) |-> (r_state == S_IDLE))
        else $error("tour end seen but engine still running");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= r_count))
        else $error("scan address ran past the point count");

    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_done < r_count))
        else $error("more results than stored points");

    a_scan_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_FETCH) |=> r_found)
        else $error("scan ended without an unvisited point");

endmodule

// ===== rtl/nearest_neighbor_tour_l1_core.sv =====
// Top level of the greedy Manhattan nearest-neighbor tour core.
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  ------------------------
//   item      in         word taken when start & !busy  i_item   (t_in_word)
//   result    out        word valid while o_strobe    o_result (t_out_word)
//
// Cycles: loading takes one word per cycle while busy is low. The word that
// carries list_end starts a run; the first result needs only a fetch and an
// emit, and every further result needs one full scan of the point store
// through its single read port and one distance-compare unit, a drain of
// the read and compare stages, then a fetch and an emit of the chosen point.
// Reset: synchronous, active low; clears the fill counters, the queue and the
// sequencer. The point store holds no reset; visited marks are cleared as each
// point is written, so no clearing pass runs.
// Stalls: busy rises when the two-word queue is full, which happens while a
// run is under way; here the receiver cannot stall, so each result is on the
// ports for exactly one cycle.
module nearest_neighbor_tour_l1_core import nntl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_result
);

    t_q_stat q_stat;
    t_q_word q_in_word, q_out_word;
    logic    q_push, q_pop;

    // Classify each word: store it, or drop it and flag the overflow.
    nntl_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_busy   (busy),
        .o_push   (q_push),
        .o_q_word (q_in_word)
    );

    // Hold classified words while the engine runs a tour.
    nntl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .i_pop   (q_pop),
        .o_word  (q_out_word),
        .o_stat  (q_stat)
    );

    // Store points and order them greedily.
    nntl_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_word (q_out_word),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== test/testbench.sv =====
// Testbench of the nearest-neighbor tour core: directed lists, random lists, tour checks.
module testbench import nntl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Default capacity of the core as instantiated below.
    localparam int CAPACITY       = MAX_POINTS_DEF;
    // Cycles with no word moving either way before the run is declared hung.
    // One tour step scans every stored point, so this is many times the slowest
    // legal gap.
    localparam int WATCHDOG_LIMIT = 1000;
    // Settle time after the last expected word: one full scan and then some.
    localparam int DRAIN_CYCLES   = CAPACITY + 16;
    // Random words per idling phase.
    localparam int PHASE_WORDS    = 60;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {
        COORD_WIDE,   // any 32-bit value
        COORD_TIGHT,  // tiny range, many ties and duplicates
        COORD_EDGE    // zero, all ones and values near them
    } t_coord_mode;

    // One row of the directed table; known counts the words typed in below.
    typedef struct packed {
        logic [COORD_W-1:0] easting;
        logic [COORD_W-1:0] northing;
        logic               list_end;
        logic [1:0]         known;
    } t_step;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_word o_result;

    nearest_neighbor_tour_l1_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed lists: a lone point, the two coordinate extremes, equal
    // distances resolved to the lowest index, a line loaded out of order so
    // that the walk must follow the current point, extremes that would wrap
    // a narrow subtractor, duplicate points, and alternating bit patterns.
    t_step directed_steps [0:21] = '{
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 2'd1},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 2'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd2},
        '{32'd100,       32'd100,       1'b0, 2'd0},
        '{32'd200,       32'd100,       1'b0, 2'd0},
        '{32'd0,         32'd100,       1'b0, 2'd0},
        '{32'd100,       32'd200,       1'b1, 2'd0},
        '{32'd0,         32'd0,         1'b0, 2'd0},
        '{32'd30,        32'd0,         1'b0, 2'd0},
        '{32'd10,        32'd0,         1'b0, 2'd0},
        '{32'd20,        32'd0,         1'b1, 2'd0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 2'd0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 2'd0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 2'd0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 2'd0},
        '{32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 2'd0},
        '{32'd5,         32'd5,         1'b0, 2'd0},
        '{32'd5,         32'd5,         1'b0, 2'd0},
        '{32'd4,         32'd6,         1'b0, 2'd0},
        '{32'd5,         32'd5,         1'b1, 2'd0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 2'd0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 2'd0}
    };

    // Tours that can be read straight off the rows above, in row order.
    t_out_word known_tour [0:2] = '{
        '{6'd0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0},
        '{6'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
        '{6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}
    };

    // Tour planner state: point store, visited marks, fill level, walk position.
    logic [COORD_W-1:0] east_mem  [CAPACITY];
    logic [COORD_W-1:0] north_mem [CAPACITY];
    bit                 seen      [CAPACITY];
    int                 fill;
    int                 walk_at;
    bit                 lost;

    t_out_word tour_plan[$];      // words of the tour just planned
    t_out_word expected_tour[$];  // words still owed by the core

    int  fault_count;
    int  words_checked;
    int  lists_sent;
    int  full_lists;
    int  lossy_lists;
    int  words_sent;
    int  known_next;
    int  idle_pct;
    int  quiet_cycles;
    bit  running;

    t_in_word next_word;

    // Store one point; on the list end, plan the whole greedy tour.
    task automatic plan_tour(input t_in_word w);
        logic [COORD_W-1:0] de;
        logic [COORD_W-1:0] dn;
        logic [DIST_W-1:0]  d;
        logic [DIST_W-1:0]  best_d;
        int                 best;
        bit                 found;
        t_out_word          plan_word;
        tour_plan.delete();
        if (fill < CAPACITY) begin
            east_mem[fill]  = w.easting;
            north_mem[fill] = w.northing;
            fill++;
        end else begin
            lost = 1'b1;
        end
        if (!w.list_end)
            return;
        if (fill == CAPACITY)
            full_lists++;
        if (lost)
            lossy_lists++;
        if (fill > 0) begin
            foreach (seen[i])
                seen[i] = 1'b0;
            walk_at = 0;
            seen[0] = 1'b1;
            plan_word = '{6'd0, east_mem[0], north_mem[0], fill == 1, lost};
            tour_plan = {tour_plan, plan_word};
            for (int step = 1; step < fill; step++) begin
                found  = 1'b0;
                best   = 0;
                best_d = '0;
                for (int i = 0; i < fill; i++) begin
                    if (!seen[i]) begin
                        de = (east_mem[i] >= east_mem[walk_at]) ?
                             east_mem[i] - east_mem[walk_at] :
                             east_mem[walk_at] - east_mem[i];
                        dn = (north_mem[i] >= north_mem[walk_at]) ?
                             north_mem[i] - north_mem[walk_at] :
                             north_mem[walk_at] - north_mem[i];
                        d = DIST_W'(de) + DIST_W'(dn);
                        // strict compare keeps the lowest index on a tie
                        if (!found || d < best_d) begin
                            found  = 1'b1;
                            best_d = d;
                            best   = i;
                        end
                    end
                end
                seen[best] = 1'b1;
                walk_at    = best;
                plan_word  = '{IDX_W'(best), east_mem[best], north_mem[best],
                               step + 1 == fill, lost};
                tour_plan  = {tour_plan, plan_word};
            end
        end
        fill = 0;
        lost = 1'b0;
    endtask

    // Offer one word, idling first at the current rate, and book its tour once taken.
    task automatic send_word(input t_in_word w, input int known);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // taken at this edge
        words_sent++;
        plan_tour(w);
        if (w.list_end)
            lists_sent++;
        if (known != 0) begin
            repeat (known) begin
                expected_tour = {expected_tour, known_tour[known_next]};
                known_next++;
            end
        end else begin
            expected_tour = {expected_tour, tour_plan};
        end
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input t_coord_mode mode);
        case (mode)
            COORD_TIGHT: return COORD_W'($urandom_range(0, 15));
            COORD_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return COORD_W'($urandom_range(0, 15));
                    default: return '1 - COORD_W'($urandom_range(0, 15));
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Load one random list of the given size; the last word closes it.
    task automatic send_list(input int size, input t_coord_mode mode);
        t_in_word w;
        for (int i = 0; i < size; i++) begin
            w.easting  = pick_coord(mode);
            w.northing = pick_coord(mode);
            w.list_end = (i == size - 1);
            send_word(w, 0);
        end
    endtask

    // Check every result word against the oldest word still owed.
    always @(posedge i_clk) begin : check_tour
        t_out_word want;
        if (running && o_strobe) begin
            if (expected_tour.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected word: index %0d e %h n %h end %b ovf %b",
                             o_result.point_index, o_result.out_easting,
                             o_result.out_northing, o_result.tour_end, o_result.overflow);
            end else begin
                want = expected_tour.pop_front();
                words_checked++;
                if (o_result.point_index  !== want.point_index  ||
                    o_result.out_easting  !== want.out_easting  ||
                    o_result.out_northing !== want.out_northing ||
                    o_result.tour_end     !== want.tour_end     ||
                    o_result.overflow     !== want.overflow) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("word %0d mismatch:", words_checked);
                        $display("  expected index %0d e %h n %h end %b ovf %b",
                                 want.point_index, want.out_easting, want.out_northing,
                                 want.tour_end, want.overflow);
                        $display("  actual   index %0d e %h n %h end %b ovf %b",
                                 o_result.point_index, o_result.out_easting,
                                 o_result.out_northing, o_result.tour_end,
                                 o_result.overflow);
                    end
                end
            end
        end
    end

    // Count cycles in which no word moves in either direction.
    always @(posedge i_clk) begin
        if (running) begin
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no word moved for %0d cycles, %0d words still owed",
                         quiet_cycles, expected_tour.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        int phase_words;
        fault_count   = 0;
        words_checked = 0;
        lists_sent    = 0;
        full_lists    = 0;
        lossy_lists   = 0;
        words_sent    = 0;
        known_next    = 0;
        quiet_cycles  = 0;
        running       = 1'b0;
        fill          = 0;
        walk_at       = 0;
        lost          = 1'b0;
        idle_pct      = 25;

        // Hold reset, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // Walk the directed table under the first idling rate.
        for (int k = 0; k < $size(directed_steps); k++) begin
            next_word.easting  = directed_steps[k].easting;
            next_word.northing = directed_steps[k].northing;
            next_word.list_end = directed_steps[k].list_end;
            send_word(next_word, int'(directed_steps[k].known));
        end

        // Random lists in three idling phases: light, heavy, none.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct    = (phase == 0) ? 25 : (phase == 1) ? 75 : 0;
            phase_words = words_sent;
            // Fill the store exactly once, and overflow it once, list end dropped too.
            if (phase == 0)
                send_list(CAPACITY, COORD_WIDE);
            else if (phase == 1)
                send_list(CAPACITY + $urandom_range(1, 3), COORD_TIGHT);
            while (words_sent - phase_words < PHASE_WORDS) begin
                if ($urandom_range(0, 7) == 0)
                    send_list($urandom_range(9, 20), t_coord_mode'($urandom_range(0, 2)));
                else
                    send_list($urandom_range(1, 8), t_coord_mode'($urandom_range(0, 2)));
            end
        end
        start <= 1'b0;

        // Drain: wait for every owed word, then watch for strays.
        while (expected_tour.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words in %0d lists (%0d filled the store, %0d lost points)",
                 words_sent, lists_sent, full_lists, lossy_lists);
        $display("checked %0d tour words, %0d mismatches", words_checked, fault_count);
        if (fault_count == 0 && expected_tour.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
